[src/jits_pkg.sv]
// Shared types, constants and fixed-point helpers for the jerk impulse trajectory sampler.
// Depends on nothing; used by the top level and the testbench.
package jits_pkg;

    localparam int MAX_SAMPLES = 4096;
    localparam int CNT_W       = $clog2(MAX_SAMPLES);
    localparam int DIV_W       = 56;
    localparam int DIV_DIGIT   = 28;
    localparam int DIV_STEPS   = DIV_W / DIV_DIGIT;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    // divide by six per digit: halve, then multiply by ceil(2^RCP_SH / 3)
    // (digit width even, so 2^RCP_SH + 1 is a multiple of 3 and the result is exact)
    localparam int RCP_SH      = DIV_DIGIT + 3;
    localparam int RP_W        = 2 * RCP_SH;
    localparam logic [RCP_SH-1:0] RECIP3 = RCP_SH'(((64'd1 << RCP_SH) + 64'd1) / 64'd3);
    localparam logic [31:0] STEP_RESET = 32'd167772;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic signed [31:0] start_pos;
        logic signed [31:0] start_vel;
        logic signed [31:0] start_acc;
        logic signed [31:0] jerk_a;
        logic signed [31:0] jerk_b;
        logic signed [31:0] jerk_c;
        logic signed [31:0] jerk_d;
        logic        [31:0] switch_b;
        logic        [31:0] switch_c;
        logic        [31:0] switch_d;
        logic        [31:0] end_time;
    } in_t;

    typedef struct packed {
        logic        [31:0] sample_time;
        logic signed [31:0] position;
        logic signed [31:0] velocity;
        logic signed [31:0] acceleration;
        logic signed [31:0] jerk_now;
        logic               last;
    } out_t;

    typedef enum logic [11:0] {
        ST_IDLE = 12'b0000_0000_0001,
        ST_TIME = 12'b0000_0000_0010,
        ST_D2   = 12'b0000_0000_0100,
        ST_D3   = 12'b0000_0000_1000,
        ST_IVP  = 12'b0000_0001_0000,
        ST_IAV  = 12'b0000_0010_0000,
        ST_IAP  = 12'b0000_0100_0000,
        ST_JA   = 12'b0000_1000_0000,
        ST_JV   = 12'b0001_0000_0000,
        ST_JP   = 12'b0010_0000_0000,
        ST_DIV  = 12'b0100_0000_0000,
        ST_FIN  = 12'b1000_0000_0000
    } state_t;

    function automatic logic [31:0] abs32(input logic signed [31:0] c);
        abs32 = c[31] ? 32'(-c) : 32'(c);
    endfunction

    function automatic logic signed [63:0] signed_term(input logic neg,
                                                       input logic [DIV_W-1:0] mag);
        logic signed [63:0] m;
        m = $signed({{(64-DIV_W){1'b0}}, mag});
        signed_term = neg ? -m : m;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            sat32 = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            sat32 = 32'sh80000000;
        else
            sat32 = v[31:0];
    endfunction

endpackage

[src/jits_mul.sv]
// Shared multi-cycle multiplier: 48 x 32 unsigned product from three 16 x 32 partial products.
// Depends on nothing; product is valid on the cycle done pulses.
module jits_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [47:0] a,
    input  logic [31:0] b,
    output logic        done,
    output logic [79:0] product
);

    logic [47:0] a_reg, a_next;
    logic [31:0] b_reg, b_next;
    logic [79:0] acc_reg, acc_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [15:0] chunk;
    logic [47:0] pp;
    logic [79:0] pp_sh;

    always_comb
    begin
        unique case (cnt_reg)
            2'd0:    chunk = a_reg[15:0];
            2'd1:    chunk = a_reg[31:16];
            default: chunk = a_reg[47:32];
        endcase
        pp = 48'(chunk) * 48'(b_reg);
        unique case (cnt_reg)
            2'd0:    pp_sh = {32'd0, pp};
            2'd1:    pp_sh = {16'd0, pp, 16'd0};
            default: pp_sh = {pp, 32'd0};
        endcase

        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_next    = a;
            b_next    = b;
            acc_next  = '0;
            cnt_next  = 2'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = acc_reg + pp_sh;
            cnt_next = cnt_reg + 2'd1;
            if (cnt_reg == 2'd2)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 2'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

[src/jerk_impulse_trajectory_sampler_unit.sv]
// Top level of the jerk impulse trajectory sampler: sequencer, state and output register.
// Depends on jits_pkg and jits_mul.
//
// A start word loads initial motion, four jerk impulses, three switch times and an end time.
// Each tick word taken while a trajectory runs yields one sample word; all products go
// through the one shared 48x32 multiplier and the position term of each impulse is divided
// by six in two 28-bit digit steps by reciprocal multiplication. A tick stalls the input
// until its sample enters the output register, and the first tick always enables one
// impulse; the final step waits while an earlier sample is still stalled in the output
// register. A finished sample waits in the output register without blocking the next word.
module jerk_impulse_trajectory_sampler_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  jits_pkg::in_t        in_word,
    output logic                 out_valid,
    input  logic                 out_stall,
    output jits_pkg::out_t       out_word,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [31:0]          cfg_data
);

    jits_pkg::state_t state_reg, state_next;

    logic [31:0]          step_reg, step_next;
    logic signed [31:0]   p0_reg, p0_next, v0_reg, v0_next, a0_reg, a0_next;
    logic signed [31:0]   jerk_reg [4];
    logic signed [31:0]   jerk_next [4];
    logic [31:0]          itime_reg [3];
    logic [31:0]          itime_next [3];
    logic [31:0]          stop_reg, stop_next;
    logic [jits_pkg::CNT_W-1:0] count_reg, count_next;
    logic [2:0]           active_reg, active_next;
    logic                 running_reg, running_next;
    logic [31:0]          t_reg, t_next, d_reg, d_next;
    logic [39:0]          d2_reg, d2_next;
    logic [47:0]          d3_reg, d3_next;
    logic signed [63:0]   pos_reg, pos_next, vel_reg, vel_next, acc_reg, acc_next;
    logic [2:0]           seg_reg, seg_next;
    logic [jits_pkg::DIV_W-1:0]     div_reg, div_next;
    logic [2:0]           rem_reg, rem_next;
    logic [jits_pkg::DIV_CNT_W-1:0] dcnt_reg, dcnt_next;
    logic                 wait_reg, wait_next;
    logic                 last_reg, last_next;
    jits_pkg::out_t       out_reg, out_next;
    logic                 ovalid_reg, ovalid_next;

    logic                 mul_start, mul_done;
    logic [47:0]          mul_a;
    logic [31:0]          mul_b;
    logic [79:0]          prod;

    logic [2:0]           jk3;
    logic [1:0]           jk;
    logic signed [31:0]   coef;
    logic [31:0]          t_calc, next_sw, tk;
    logic [2:0]           act_calc;
    logic [jits_pkg::DIV_DIGIT+2:0] div_val, div_q6;
    logic [jits_pkg::RP_W-1:0]      div_rp;
    logic [jits_pkg::DIV_DIGIT-1:0] div_q;
    logic [2:0]           div_rem;
    logic signed [33:0]   jsum;
    logic                 advance;

    jits_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (prod)
    );

    assign jk3 = seg_reg - 3'd1;
    assign jk  = jk3[1:0];

    always_comb
    begin
        unique case (state_reg)
            jits_pkg::ST_IVP:                   coef = v0_reg;
            jits_pkg::ST_IAV, jits_pkg::ST_IAP: coef = a0_reg;
            default:                            coef = jerk_reg[jk];
        endcase

        unique case (state_reg)
            jits_pkg::ST_TIME:
            begin
                mul_a = 48'(count_reg);
                mul_b = step_reg;
            end
            jits_pkg::ST_D2:
            begin
                mul_a = 48'(d_reg);
                mul_b = d_reg;
            end
            jits_pkg::ST_D3:
            begin
                mul_a = 48'(d2_reg);
                mul_b = d_reg;
            end
            jits_pkg::ST_IVP, jits_pkg::ST_IAV, jits_pkg::ST_JA:
            begin
                mul_a = 48'(d_reg);
                mul_b = jits_pkg::abs32(coef);
            end
            jits_pkg::ST_IAP, jits_pkg::ST_JV:
            begin
                mul_a = 48'(d2_reg);
                mul_b = jits_pkg::abs32(coef);
            end
            default:
            begin
                mul_a = d3_reg;
                mul_b = jits_pkg::abs32(coef);
            end
        endcase

        t_calc = (|prod[79:32]) ? 32'hFFFFFFFF : prod[31:0];
        next_sw = (active_reg == 3'd0) ? 32'd0 : itime_reg[2'(active_reg - 3'd1)];
        act_calc = active_reg;
        if (active_reg < 3'd4 && t_calc >= next_sw)
            act_calc = active_reg + 3'd1;

        tk = (seg_reg == 3'd0) ? 32'd0 : itime_reg[2'(seg_reg - 3'd1)];

        // one long-division digit by six: floor(v / 6) = floor(floor(v / 2) / 3)
        div_val = {rem_reg, div_reg[jits_pkg::DIV_W-1 -: jits_pkg::DIV_DIGIT]};
        div_rp  = jits_pkg::RP_W'(div_val[jits_pkg::DIV_DIGIT+2:1])
                * jits_pkg::RP_W'(jits_pkg::RECIP3);
        div_q   = div_rp[jits_pkg::RCP_SH+jits_pkg::DIV_DIGIT-1:jits_pkg::RCP_SH];
        div_q6  = {1'b0, div_q, 2'b00} + {2'b00, div_q, 1'b0};
        div_rem = 3'(div_val - div_q6);

        jsum = '0;
        for (int k = 0; k < 4; k++)
        begin
            if (3'(k) < active_reg)
                jsum = jsum + 34'(jerk_reg[k]);
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        p0_next      = p0_reg;
        v0_next      = v0_reg;
        a0_next      = a0_reg;
        jerk_next    = jerk_reg;
        itime_next   = itime_reg;
        stop_next    = stop_reg;
        count_next   = count_reg;
        active_next  = active_reg;
        running_next = running_reg;
        t_next       = t_reg;
        d_next       = d_reg;
        d2_next      = d2_reg;
        d3_next      = d3_reg;
        pos_next     = pos_reg;
        vel_next     = vel_reg;
        acc_next     = acc_reg;
        seg_next     = seg_reg;
        div_next     = div_reg;
        rem_next     = rem_reg;
        dcnt_next    = dcnt_reg;
        wait_next    = wait_reg;
        last_next    = last_reg;
        out_next     = out_reg;
        ovalid_next  = ovalid_reg;
        mul_start    = 1'b0;
        advance      = 1'b0;

        if (ovalid_reg && !out_stall)
            ovalid_next = 1'b0;

        if (cfg_valid)
            step_next = cfg_data;

        unique case (state_reg)
            jits_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_word.req_type == jits_pkg::REQ_START)
                    begin
                        p0_next       = in_word.start_pos;
                        v0_next       = in_word.start_vel;
                        a0_next       = in_word.start_acc;
                        jerk_next[0]  = in_word.jerk_a;
                        jerk_next[1]  = in_word.jerk_b;
                        jerk_next[2]  = in_word.jerk_c;
                        jerk_next[3]  = in_word.jerk_d;
                        itime_next[0] = in_word.switch_b;
                        itime_next[1] = in_word.switch_c;
                        itime_next[2] = in_word.switch_d;
                        stop_next     = in_word.end_time;
                        count_next    = '0;
                        active_next   = 3'd0;
                        running_next  = 1'b1;
                    end
                    else if (running_reg)
                    begin
                        wait_next  = 1'b0;
                        state_next = jits_pkg::ST_TIME;
                    end
                end
            end

            jits_pkg::ST_DIV:
            begin
                rem_next  = div_rem;
                div_next  = {div_reg[jits_pkg::DIV_W-jits_pkg::DIV_DIGIT-1:0], div_q};
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == jits_pkg::DIV_CNT_W'(jits_pkg::DIV_STEPS - 1))
                begin
                    pos_next = pos_reg + jits_pkg::signed_term(coef[31], div_next);
                    advance  = 1'b1;
                end
            end

            jits_pkg::ST_FIN:
            begin
                if (!ovalid_reg || !out_stall)
                begin
                    out_next.sample_time  = t_reg;
                    out_next.position     = jits_pkg::sat32(pos_reg);
                    out_next.velocity     = jits_pkg::sat32(vel_reg);
                    out_next.acceleration = jits_pkg::sat32(acc_reg);
                    out_next.jerk_now     = jits_pkg::sat32(64'(jsum));
                    out_next.last         = last_reg;
                    ovalid_next           = 1'b1;
                    if (last_reg)
                        running_next = 1'b0;
                    else
                        count_next = count_reg + 1'b1;
                    state_next = jits_pkg::ST_IDLE;
                end
            end

            default:
            begin
                if (!wait_reg)
                begin
                    mul_start = 1'b1;
                    wait_next = 1'b1;
                end
                else if (mul_done)
                begin
                    wait_next = 1'b0;
                    unique case (state_reg)
                        jits_pkg::ST_TIME:
                        begin
                            t_next      = t_calc;
                            d_next      = t_calc;
                            active_next = act_calc;
                            last_next   = (t_calc >= stop_reg) ||
                                (count_reg == jits_pkg::CNT_W'(jits_pkg::MAX_SAMPLES - 1));
                            pos_next    = 64'(p0_reg);
                            vel_next    = 64'(v0_reg);
                            acc_next    = 64'(a0_reg);
                            seg_next    = 3'd0;
                            state_next  = jits_pkg::ST_D2;
                        end
                        jits_pkg::ST_D2:
                        begin
                            d2_next    = prod[63:24];
                            state_next = (seg_reg == 3'd0) ? jits_pkg::ST_IVP : jits_pkg::ST_D3;
                        end
                        jits_pkg::ST_D3:
                        begin
                            d3_next    = prod[71:24];
                            state_next = jits_pkg::ST_JA;
                        end
                        jits_pkg::ST_IVP:
                        begin
                            pos_next   = pos_reg + jits_pkg::signed_term(coef[31], prod[79:24]);
                            state_next = jits_pkg::ST_IAV;
                        end
                        jits_pkg::ST_IAV:
                        begin
                            vel_next   = vel_reg + jits_pkg::signed_term(coef[31], prod[79:24]);
                            state_next = jits_pkg::ST_IAP;
                        end
                        jits_pkg::ST_IAP:
                        begin
                            pos_next = pos_reg + jits_pkg::signed_term(coef[31],
                                {1'b0, prod[79:25]});
                            advance  = 1'b1;
                        end
                        jits_pkg::ST_JA:
                        begin
                            acc_next   = acc_reg + jits_pkg::signed_term(coef[31], prod[79:24]);
                            state_next = jits_pkg::ST_JV;
                        end
                        jits_pkg::ST_JV:
                        begin
                            vel_next = vel_reg + jits_pkg::signed_term(coef[31],
                                {1'b0, prod[79:25]});
                            state_next = jits_pkg::ST_JP;
                        end
                        default:
                        begin
                            div_next   = prod[79:24];
                            rem_next   = 3'd0;
                            dcnt_next  = '0;
                            state_next = jits_pkg::ST_DIV;
                        end
                    endcase
                end
            end
        endcase

        if (advance)
        begin
            if (seg_reg < active_next)
            begin
                seg_next   = seg_reg + 3'd1;
                d_next     = (t_reg >= tk) ? t_reg - tk : 32'd0;
                state_next = jits_pkg::ST_D2;
            end
            else
                state_next = jits_pkg::ST_FIN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= jits_pkg::ST_IDLE;
            step_reg    <= jits_pkg::STEP_RESET;
            p0_reg      <= '0;
            v0_reg      <= '0;
            a0_reg      <= '0;
            for (int k = 0; k < 4; k++)
                jerk_reg[k] <= '0;
            for (int k = 0; k < 3; k++)
                itime_reg[k] <= '0;
            stop_reg    <= '0;
            count_reg   <= '0;
            active_reg  <= 3'd0;
            running_reg <= 1'b0;
            seg_reg     <= 3'd0;
            dcnt_reg    <= '0;
            wait_reg    <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            p0_reg      <= p0_next;
            v0_reg      <= v0_next;
            a0_reg      <= a0_next;
            jerk_reg    <= jerk_next;
            itime_reg   <= itime_next;
            stop_reg    <= stop_next;
            count_reg   <= count_next;
            active_reg  <= active_next;
            running_reg <= running_next;
            seg_reg     <= seg_next;
            dcnt_reg    <= dcnt_next;
            wait_reg    <= wait_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg    <= t_next;
        d_reg    <= d_next;
        d2_reg   <= d2_next;
        d3_reg   <= d3_next;
        pos_reg  <= pos_next;
        vel_reg  <= vel_next;
        acc_reg  <= acc_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        last_reg <= last_next;
        out_reg  <= out_next;
    end

    assign in_stall  = (state_reg != jits_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = ovalid_reg;
    assign out_word  = out_reg;

endmodule

[sim/jerk_impulse_trajectory_sampler_unit_tb.sv]
// Testbench for jerk_impulse_trajectory_sampler_unit: directed and random trajectories checked
// against a cycle-free motion predictor, with random input gaps and output stalls.
// Depends on jits_pkg and the sampler RTL.
module jerk_impulse_trajectory_sampler_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  SETTLE      = 400;
    localparam longint LIMIT    = 8000000;
    localparam logic [63:0] CAP = 64'h1000_0000_0000_0000;

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_stall;
    jits_pkg::in_t   in_word;
    logic            out_valid;
    logic            out_stall;
    jits_pkg::out_t  out_word;
    logic            cfg_valid;
    logic            cfg_ready;
    logic [31:0]     cfg_data;

    jerk_impulse_trajectory_sampler_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [31:0]        step_q;
    logic signed [31:0] m_init [3];
    logic signed [31:0] m_jerk [4];
    logic [31:0]        m_sw   [3];
    logic [31:0]        m_stop;
    logic [31:0]        m_cnt;
    int                 m_act;
    bit                 m_run;

    jits_pkg::out_t samples_q[$];
    int     fails;
    longint cycles;
    int     words_sent;
    int     hold_req;
    int     hold_left;
    int     burst_left;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("** jerk_impulse_trajectory_sampler_unit: FAILED **");
            $finish;
        end
    end

    function automatic logic [63:0] mul_shift(logic [63:0] a, logic [31:0] b, int s);
        logic [95:0] p;
        p = ({32'd0, a} * {64'd0, b}) >> s;
        return (p[95:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : p[63:0];
    endfunction

    function automatic logic signed [63:0] motion_term(logic signed [31:0] c, logic [63:0] f,
                                                       int s, int dv);
        logic signed [63:0] cs;
        logic [63:0]        r;
        cs = c;
        if (cs < 0)
            cs = -cs;
        r = mul_shift(f, cs[31:0], s) / dv;
        if (r > CAP)
            r = CAP;
        return c[31] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // advance the predictor by one accepted word
    function automatic void predict_sample(jits_pkg::in_t w);
        logic [63:0]        tw, t2, d, d2, d3;
        logic [31:0]        t, tk, nxt;
        logic signed [63:0] pos, vel, acc, js;
        jits_pkg::out_t     o;
        if (w.req_type == jits_pkg::REQ_START)
        begin
            m_init[0] = w.start_pos;
            m_init[1] = w.start_vel;
            m_init[2] = w.start_acc;
            m_jerk[0] = w.jerk_a;
            m_jerk[1] = w.jerk_b;
            m_jerk[2] = w.jerk_c;
            m_jerk[3] = w.jerk_d;
            m_sw[0]   = w.switch_b;
            m_sw[1]   = w.switch_c;
            m_sw[2]   = w.switch_d;
            m_stop    = w.end_time;
            m_cnt     = 0;
            m_act     = 0;
            m_run     = 1;
            return;
        end
        if (!m_run)
            return;
        tw = {32'd0, m_cnt} * {32'd0, step_q};
        t  = (tw > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : tw[31:0];
        if (m_act < 4)
        begin
            nxt = (m_act == 0) ? 32'd0 : m_sw[m_act-1];
            if (t >= nxt)
                m_act++;
        end
        t2  = mul_shift({32'd0, t}, t, 24);
        pos = 64'(m_init[0]) + motion_term(m_init[1], {32'd0, t}, 24, 1)
            + motion_term(m_init[2], t2, 25, 1);
        vel = 64'(m_init[1]) + motion_term(m_init[2], {32'd0, t}, 24, 1);
        acc = 64'(m_init[2]);
        js  = 0;
        for (int k = 0; k < m_act; k++)
        begin
            tk  = (k == 0) ? 32'd0 : m_sw[k-1];
            d   = (t >= tk) ? {32'd0, t - tk} : 64'd0;
            d2  = mul_shift(d, d[31:0], 24);
            d3  = mul_shift(d2, d[31:0], 24);
            js  += 64'(m_jerk[k]);
            acc += motion_term(m_jerk[k], d, 24, 1);
            vel += motion_term(m_jerk[k], d2, 25, 1);
            pos += motion_term(m_jerk[k], d3, 24, 6);
        end
        o.sample_time  = t;
        o.position     = clamp32(pos);
        o.velocity     = clamp32(vel);
        o.acceleration = clamp32(acc);
        o.jerk_now     = clamp32(js);
        o.last         = (t >= m_stop) || (m_cnt + 1 >= jits_pkg::MAX_SAMPLES);
        samples_q = {samples_q, o};
        if (o.last)
            m_run = 0;
        else
            m_cnt++;
    endfunction

    // sender: bursts with random gaps
    task automatic send_word(jits_pkg::in_t w);
        if (burst_left == 0)
        begin
            repeat ($urandom_range(1, 20)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 30);
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        in_word  <= w;
        do
            @(posedge clk);
        while (in_stall);
        predict_sample(w);
        words_sent++;
        @(negedge clk);
        in_valid <= 1'b0;
        in_word  <= jits_pkg::in_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                     $urandom, $urandom, $urandom, $urandom, $urandom,
                                     $urandom, $urandom});
    endtask

    task automatic send_tick();
        jits_pkg::in_t w;
        w = jits_pkg::in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        w.req_type = jits_pkg::REQ_TICK;
        send_word(w);
    endtask

    task automatic send_start(logic [31:0] p, logic [31:0] v, logic [31:0] a,
                              logic [31:0] ja, logic [31:0] jb, logic [31:0] jc,
                              logic [31:0] jd, logic [31:0] sb, logic [31:0] sc,
                              logic [31:0] sd, logic [31:0] e);
        jits_pkg::in_t w;
        w = '{jits_pkg::REQ_START, p, v, a, ja, jb, jc, jd, sb, sc, sd, e};
        send_word(w);
    endtask

    task automatic wait_drained();
        while (samples_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_step(logic [31:0] v);
        wait_drained();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        step_q = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_motion();
        unique case ($urandom_range(0, 9))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'd0;
            3: return $urandom;
            default: return $signed($urandom) >>> $urandom_range(4, 24);
        endcase
    endfunction

    function automatic logic [31:0] time_at(int n);
        logic [63:0] v;
        v = 64'(n) * step_q;
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    task automatic run_random_trajectory();
        int          n;
        logic [31:0] e, s[3], x;
        n = $urandom_range(0, 14);
        e = time_at(n);
        if ($urandom_range(0, 3) == 0 && e < 32'hFFFF_FFFF - step_q)
            e = e + $urandom_range(0, step_q - 1);
        for (int i = 0; i < 3; i++)
            s[i] = ($urandom_range(0, 4) == 0) ? $urandom : time_at($urandom_range(0, n + 1));
        if ($urandom_range(0, 2) != 0)
            for (int i = 0; i < 2; i++)
                for (int j = 0; j < 2 - i; j++)
                    if (s[j] > s[j+1])
                    begin
                        x = s[j];
                        s[j] = s[j+1];
                        s[j+1] = x;
                    end
        send_start(rand_motion(), rand_motion(), rand_motion(), rand_motion(), rand_motion(),
                   rand_motion(), rand_motion(), s[0], s[1], s[2], e);
        for (int i = 0; i <= n + 1 && m_run; i++)
        begin
            if ($urandom_range(0, 30) == 0)
                return;
            send_tick();
        end
        if ($urandom_range(0, 5) == 0)
            send_tick();
    endtask

    task automatic test_idle_ticks();
        send_tick();
        send_tick();
    endtask

    task automatic test_extremes();
        send_start(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                   32'h7FFFFFFF, 32'h80000000, 0, 0, 0, time_at(4));
        repeat (6) send_tick();
        send_start(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                   32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0);
        send_tick();
    endtask

    task automatic test_unsorted_switch();
        send_start(32'h0001_0000, 32'h0000_8000, 32'hFFFF_0000, 32'h0010_0000, 32'hFFE0_0000,
                   32'h0030_0000, 32'hFFC0_0000, time_at(5), time_at(1), time_at(2),
                   time_at(7));
        repeat (8) send_tick();
    endtask

    task automatic test_restart();
        send_start(32'h0100_0000, 0, 32'h0002_0000, 32'h0005_0000, 0, 0, 0,
                   time_at(1), time_at(2), time_at(3), time_at(20));
        repeat (3) send_tick();
        send_start(0, 32'h0003_0000, 0, 32'hFFFB_0000, 32'h0005_0000, 0, 0,
                   time_at(1), time_at(1), time_at(2), time_at(2));
        repeat (4) send_tick();
    endtask

    task automatic test_step_extremes();
        write_step(32'hFFFF_FFFF);
        send_start(32'h0000_1000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0,
                   1, 2, 3, 32'hFFFF_FFFE);
        repeat (3) send_tick();
        write_step(32'd1);
        send_start(32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F, 32'h7FFFFFFF, 32'h80000000,
                   32'h1, 32'hFFFFFFFF, 1, 2, 3, 5);
        repeat (7) send_tick();
    endtask

    task automatic test_backpressure();
        wait_drained();
        hold_req = 900;
        send_start(32'h0002_0000, 32'h0001_0000, 32'hFFFF_8000, 32'h0008_0000, 32'hFFF8_0000,
                   32'h0004_0000, 32'hFFFC_0000, time_at(1), time_at(2), time_at(3),
                   time_at(11));
        repeat (12) send_tick();
    endtask

    task automatic test_random(logic [31:0] step, int quota);
        int start_cnt;
        write_step(step);
        start_cnt = words_sent;
        while (words_sent - start_cnt < quota)
            run_random_trajectory();
    endtask

    // receiver stall pattern, with an optional long hold-off
    always @(negedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            unique case ((cycles / 97) % 4)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 9) < 3);
                2: out_stall <= ($urandom_range(0, 9) < 8);
                default: out_stall <= (cycles % 5) < 2;
            endcase
    end

    always @(posedge clk)
    begin
        jits_pkg::out_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (samples_q.size() == 0)
            begin
                $error("sample word with none expected");
                fails++;
            end
            else
            begin
                e = samples_q.pop_front();
                if (out_word.sample_time !== e.sample_time)
                begin
                    $error("sample_time exp %h got %h", e.sample_time, out_word.sample_time);
                    fails++;
                end
                if (out_word.position !== e.position)
                begin
                    $error("position exp %h got %h", e.position, out_word.position);
                    fails++;
                end
                if (out_word.velocity !== e.velocity)
                begin
                    $error("velocity exp %h got %h", e.velocity, out_word.velocity);
                    fails++;
                end
                if (out_word.acceleration !== e.acceleration)
                begin
                    $error("acceleration exp %h got %h", e.acceleration, out_word.acceleration);
                    fails++;
                end
                if (out_word.jerk_now !== e.jerk_now)
                begin
                    $error("jerk_now exp %h got %h", e.jerk_now, out_word.jerk_now);
                    fails++;
                end
                if (out_word.last !== e.last)
                begin
                    $error("last exp %b got %b", e.last, out_word.last);
                    fails++;
                end
            end
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_word    = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        out_stall  = 1'b0;
        cycles     = 0;
        fails      = 0;
        words_sent = 0;
        hold_req   = 0;
        hold_left  = 0;
        burst_left = 0;
        step_q     = jits_pkg::STEP_RESET;
        m_run      = 0;
        m_cnt      = 0;
        m_act      = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_idle_ticks();
        test_extremes();
        test_unsorted_switch();
        test_restart();
        test_idle_ticks();
        test_step_extremes();
        test_random(32'd1, 200);
        test_random(32'hFFFF_FFFF, 150);
        test_random(jits_pkg::STEP_RESET, 400);
        test_backpressure();
        test_random($urandom_range(32'h0001_0000, 32'h0100_0000), 350);
        test_random($urandom, 200);
        test_random(32'd1, 10);
        test_random(jits_pkg::STEP_RESET, 100);

        wait_drained();
        if (fails == 0)
            $display("** jerk_impulse_trajectory_sampler_unit: PASSED **");
        else
            $display("** jerk_impulse_trajectory_sampler_unit: FAILED **");
        $finish;
    end

endmodule
